/* src/adex_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_pkg
// Shared widths, types and helpers for the AdEx neuron Euler step pipeline.
// ---------------------------------------------------------------------------
package adex_pkg;

	localparam int DATA_W = 32;
	localparam int IN_W   = 128;   // four 32-bit input fields
	localparam int OUT_W  = 96;    // three 32-bit result fields
	localparam int CFG_AW = 3;
	localparam int ARG_W  = 30;    // exponent argument, Q16
	localparam int EXP_W  = 28;    // exponential value, Q16, max exp(8)
	localparam int SPAN_BITS = 20;

	// exponent argument clamp, 8.0 in Q16
	localparam logic signed [ARG_W-1:0] ARG_LIMIT = ARG_W'(32'sd524288);

	typedef enum logic [CFG_AW-1:0] {
		REG_REST_POTENTIAL  = 3'd0,
		REG_INV_SLOPE       = 3'd1,
		REG_EXP_GAIN        = 3'd2,
		REG_LEAK_COEFF      = 3'd3,
		REG_CURRENT_COEFF   = 3'd4,
		REG_THRESHOLD_REST  = 3'd5,
		REG_RESET_POTENTIAL = 3'd6,
		REG_THRESHOLD_MAX   = 3'd7
	} cfg_idx_e;

	// stage enables handed to the exponential unit
	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} exp_ctl_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [47:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 48'sh0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

/* src/adex_exp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_exp
// Two-stage exponential: clamp + table read, then linear interpolation.
// ---------------------------------------------------------------------------
module adex_exp #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  adex_pkg::exp_ctl_t                  ctl,
	input  logic signed [adex_pkg::ARG_W-1:0]   arg,
	output logic        [adex_pkg::EXP_W-1:0]   ex
);
	import adex_pkg::*;

	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int POS_W = SPAN_BITS + 1 + IDX_W;

	typedef logic [EXP_W-1:0] tbl_t [EXP_TABLE_DEPTH+1];

	// shift-subtract quotient, used only while the table is built
	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r    = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// truncating Taylor series in Q24, terms up to the 20th power
	function automatic logic [63:0] taylor(input logic [63:0] f);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = 64'd1 << 24;
		term = 64'd1 << 24;
		for (int k = 1; k <= 20; k++) begin
			term = udiv((term * f) >> 24, 64'(k));
			sum  = sum + term;
		end
		return sum;
	endfunction

	// exp(-8 .. +8) in Q16, one entry per table step
	function automatic tbl_t build_tbl();
		tbl_t        t;
		logic [63:0] e;
		logic [63:0] einv;
		logic [63:0] p;
		logic [63:0] v;
		int          net;
		e    = taylor(64'd1 << 24);
		einv = udiv((64'd1 << 48) + (e >> 1), e);
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			p   = udiv(64'(k) << 28, 64'(EXP_TABLE_DEPTH));
			net = int'(p >> 24) - 8;
			v   = taylor(p & ((64'd1 << 24) - 1));
			for (int j = 0; j < 8; j++) begin
				if (j < net)
					v = (v * e) >> 24;
				if (j < -net)
					v = (v * einv) >> 24;
			end
			t[k] = EXP_W'((v + 64'd128) >> 8);
		end
		return t;
	endfunction

	localparam tbl_t EXP_TBL = build_tbl();

	logic signed [ARG_W-1:0]     arg_c;
	logic        [SPAN_BITS:0]   u;
	logic        [POS_W-1:0]     pos;
	logic        [IDX_W-1:0]     idx;
	logic        [IDX_W-1:0]     idx_hi;
	logic        [EXP_W-1:0]     lo;
	logic        [EXP_W-1:0]     hi;
	logic        [EXP_W-1:0]     lo_s3;
	logic        [EXP_W-1:0]     diff_s3;
	logic        [SPAN_BITS-1:0] fr_s3;
	logic        [EXP_W+SPAN_BITS-1:0] prod;

	// clamp and split into table index and fraction
	always_comb begin
		if (arg > ARG_LIMIT)
			arg_c = ARG_LIMIT;
		else if (arg < -ARG_LIMIT)
			arg_c = -ARG_LIMIT;
		else
			arg_c = arg;
		u      = (SPAN_BITS+1)'(arg_c + ARG_LIMIT);
		pos    = POS_W'(u) * POS_W'(EXP_TABLE_DEPTH);
		idx    = pos[SPAN_BITS +: IDX_W];
		idx_hi = (idx >= IDX_W'(EXP_TABLE_DEPTH)) ? IDX_W'(EXP_TABLE_DEPTH) : idx + 1'b1;
		lo     = EXP_TBL[idx];
		hi     = EXP_TBL[idx_hi];
		if (hi < lo)
			hi = lo;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			lo_s3   <= lo;
			diff_s3 <= hi - lo;
			fr_s3   <= pos[SPAN_BITS-1:0];
		end
	end

	// interpolation
	assign prod = (EXP_W+SPAN_BITS)'(diff_s3) * (EXP_W+SPAN_BITS)'(fr_s3);

	always_ff @(posedge clk) begin
		if (ctl.en_s4)
			ex <= lo_s3 + prod[SPAN_BITS +: EXP_W];
	end

endmodule

/* src/adex_neuron_euler_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_neuron_euler_step
// One forward-Euler AdEx neuron update per request, six-stage pipeline.
// ---------------------------------------------------------------------------
// Channel | Dir | Contents
// s_*     | in  | neuron state + input current, tlast = end of tick
// m_*     | out | updated state, tuser = spike, tlast = tick done
// cfg_*   | in  | register writes, no read-back
//
// Six registered stages lie from input request to output request; one neuron
// enters per cycle unless the output stalls. Three multiplier stages lie in
// series (argument scale, interpolation, exponential gain). Each stage holds
// its request while the next is full, so stalls pass back without loss.
// After reset the pipeline is empty and registers hold their defaults.
module adex_neuron_euler_step #(
	parameter int THRESH_DECAY_Q16   = 1311,
	parameter int ADAPT_DECAY_Q16    = 455,
	parameter int ADAPT_COUPLING_Q16 = 1820,
	parameter int SPIKE_ADAPT_JUMP   = 5275648,
	parameter int EXP_TABLE_DEPTH    = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// membrane_v, threshold_v, adapt_current, input_current
	input  logic [adex_pkg::IN_W-1:0]     s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// new_membrane_v, new_threshold_v, new_adapt_current
	output logic [adex_pkg::OUT_W-1:0]    m_tdata,
	// spike
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [adex_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [adex_pkg::DATA_W-1:0]   cfg_wdata
);
	import adex_pkg::*;

	// configuration registers
	logic signed [31:0] rest_q, th_rest_q, reset_v_q, th_max_q;
	logic        [19:0] inv_slope_q;
	logic        [30:0] exp_gain_q;
	logic        [15:0] leak_q;
	logic        [23:0] cur_coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q      <= -32'sd1184471450;
			inv_slope_q <= 20'd32768;
			exp_gain_q  <= 31'd3581936;
			leak_q      <= 16'd6997;
			cur_coeff_q <= 24'd59705;
			th_rest_q   <= -32'sd754974720;
			reset_v_q   <= -32'sd1184471450;
			th_max_q    <= 32'sd301989888;
		end else if (cfg_we) begin
			case (cfg_idx_e'(cfg_addr))
				REG_REST_POTENTIAL:  rest_q      <= cfg_wdata;
				REG_INV_SLOPE:       inv_slope_q <= cfg_wdata[19:0];
				REG_EXP_GAIN:        exp_gain_q  <= cfg_wdata[30:0];
				REG_LEAK_COEFF:      leak_q      <= cfg_wdata[15:0];
				REG_CURRENT_COEFF:   cur_coeff_q <= cfg_wdata[23:0];
				REG_THRESHOLD_REST:  th_rest_q   <= cfg_wdata;
				REG_RESET_POTENTIAL: reset_v_q   <= cfg_wdata;
				REG_THRESHOLD_MAX:   th_max_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline valids and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6     = !m_tvalid || m_tready;
	assign adv5     = !v_s5 || adv6;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; m_tvalid <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) m_tvalid <= v_s5;
		end
	end

	logic signed [31:0] in_v, in_vt, in_x, in_i;
	assign in_v  = s_tdata[31:0];
	assign in_vt = s_tdata[63:32];
	assign in_x  = s_tdata[95:64];
	assign in_i  = s_tdata[127:96];

	// stage 1: differences
	logic signed [32:0] d_s1, lk_s1, dr_s1, th_s1, ad_s1;
	logic signed [31:0] v_s1d, vt_s1, x_s1;
	logic               tk_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			d_s1  <= 33'(in_v) - 33'(in_vt);
			lk_s1 <= 33'(rest_q) - 33'(in_v);
			dr_s1 <= 33'(in_i) - 33'(in_x);
			th_s1 <= 33'(in_vt) - 33'(th_rest_q);
			ad_s1 <= 33'(in_v) - 33'(rest_q);
			v_s1d <= in_v;
			vt_s1 <= in_vt;
			x_s1  <= in_x;
			tk_s1 <= s_tlast;
		end
	end

	// stage 2: products, floor shifts
	logic signed [53:0] p_arg, p_ad;
	logic signed [49:0] p_lk, p_th;
	logic signed [57:0] p_dr;
	logic signed [48:0] p_xd;

	assign p_arg = 54'(d_s1) * 54'($signed({1'b0, inv_slope_q}));
	assign p_lk  = 50'(lk_s1) * 50'($signed({1'b0, leak_q}));
	assign p_dr  = 58'(dr_s1) * 58'($signed({1'b0, cur_coeff_q}));
	assign p_th  = 50'(th_s1) * 50'($signed({1'b0, 16'(THRESH_DECAY_Q16)}));
	assign p_ad  = 54'(ad_s1) * 54'($signed({1'b0, 20'(ADAPT_COUPLING_Q16)}));
	assign p_xd  = 49'(x_s1) * 49'($signed({1'b0, 16'(ADAPT_DECAY_Q16)}));

	logic signed [ARG_W-1:0] arg_s2;
	logic signed [33:0]      lk_s2, th_s2;
	logic signed [41:0]      dr_s2;
	logic signed [29:0]      ad_s2;
	logic signed [32:0]      xd_s2;
	logic signed [31:0]      v_s2d, vt_s2, x_s2;
	logic                    tk_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			arg_s2 <= p_arg[53:24];
			lk_s2  <= p_lk[49:16];
			dr_s2  <= p_dr[57:16];
			th_s2  <= p_th[49:16];
			ad_s2  <= p_ad[53:24];
			xd_s2  <= p_xd[48:16];
			v_s2d  <= v_s1d;
			vt_s2  <= vt_s1;
			x_s2   <= x_s1;
			tk_s2  <= tk_s1;
		end
	end

	// stages 3-4: exponential unit
	exp_ctl_t         exp_ctl;
	logic [EXP_W-1:0] ex_s4;

	assign exp_ctl.en_s3 = adv3;
	assign exp_ctl.en_s4 = adv4;

	adex_exp #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_exp (
		.clk(clk),
		.ctl(exp_ctl),
		.arg(arg_s2),
		.ex (ex_s4)
	);

	// stage 3: threshold, adaptation, partial voltage sum
	logic signed [43:0] part_s3;
	logic signed [31:0] nvt_s3, nx_s3;
	logic               tk_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			part_s3 <= 44'(v_s2d) + 44'(lk_s2) + 44'(dr_s2);
			nvt_s3  <= sat32(48'(vt_s2) - 48'(th_s2));
			nx_s3   <= sat32(48'(x_s2) + 48'(ad_s2) - 48'(xd_s2));
			tk_s3   <= tk_s2;
		end
	end

	logic signed [43:0] part_s4;
	logic signed [31:0] nvt_s4, nx_s4;
	logic               tk_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			part_s4 <= part_s3;
			nvt_s4  <= nvt_s3;
			nx_s4   <= nx_s3;
			tk_s4   <= tk_s3;
		end
	end

	// stage 5: exponential gain
	logic [58:0]        p_exp;
	logic [42:0]        expo_s5;
	logic signed [43:0] part_s5;
	logic signed [31:0] nvt_s5, nx_s5;
	logic               tk_s5;

	assign p_exp = 59'(exp_gain_q) * 59'(ex_s4);

	always_ff @(posedge clk) begin
		if (adv5) begin
			expo_s5 <= p_exp[58:16];
			part_s5 <= part_s4;
			nvt_s5  <= nvt_s4;
			nx_s5   <= nx_s4;
			tk_s5   <= tk_s4;
		end
	end

	// stage 6: final sum, spike decision, output register
	logic signed [31:0] nvm;
	logic               spk;

	assign nvm = sat32(48'(part_s5) + 48'($signed({1'b0, expo_s5})));
	assign spk = nvm > nvt_s5;

	always_ff @(posedge clk) begin
		if (adv6) begin
			m_tdata[31:0]  <= spk ? reset_v_q : nvm;
			m_tdata[63:32] <= spk ? th_max_q : nvt_s5;
			m_tdata[95:64] <= spk ? sat32(48'(nx_s5) + 48'(SPIKE_ADAPT_JUMP)) : nx_s5;
			m_tuser        <= spk;
			m_tlast        <= tk_s5;
		end
	end

`ifndef SYNTHESIS
	// a spiking result carries the reset potential and max threshold
	a_spike_reset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == reset_v_q && m_tdata[63:32] == th_max_q)
		else $error("spike result without reset values");

	// a quiet result never lies above its threshold
	a_quiet_below: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> $signed(m_tdata[31:0]) <= $signed(m_tdata[63:32]))
		else $error("non-spiking voltage above threshold");

	// a full stage that cannot advance keeps its request
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !adv5 |=> v_s5)
		else $error("stage 5 request dropped under stall");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AdEx Euler step pipeline. Corner neurons under
// reset register values, then randomized states under several register
// settings and handshake idle patterns, are streamed through the block. Each
// result is checked against an in-bench fixed-point model or hand values.
// ---------------------------------------------------------------------------
module tb_top;
	import adex_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int TBL_DEPTH      = 256;
	localparam longint ARG_CLAMP  = 64'sd524288;
	localparam longint SPIKE_JUMP = 64'sd5275648;

	typedef struct {
		logic signed [31:0] vm;
		logic signed [31:0] vt;
		logic signed [31:0] x;
		logic signed [31:0] cur;
		logic               last;
	} neuron_t;

	typedef struct {
		logic signed [31:0] vm;
		logic signed [31:0] vt;
		logic signed [31:0] x;
		logic               spike;
		logic               tick;
	} update_t;

	// directed row: neuron plus an optional hand-derived voltage/threshold/spike
	typedef struct {
		neuron_t            n;
		bit                 typed;
		logic signed [31:0] vm;
		logic signed [31:0] vt;
		logic               spike;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_addr;
	logic [DATA_W-1:0]   cfg_wdata;

	// register copies
	longint          rest_pot;
	longint unsigned inv_slope;
	longint unsigned exp_gain;
	longint unsigned leak_coeff;
	longint unsigned cur_coeff;
	longint          thr_rest;
	longint          reset_pot;
	longint          thr_max;

	longint unsigned exp_lut [TBL_DEPTH+1];
	update_t         pending_updates [$];
	row_t            pending_typed [$];
	int              error_count;
	int              idle_cycles;
	int              send_idle_pct;
	int              recv_stall_pct;
	bit              hold_req;
	int              hold_cnt;

	adex_neuron_euler_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// truncating Taylor series of exp(f), Q24
	function automatic longint unsigned taylor_exp(longint unsigned f);
		longint unsigned sum;
		longint unsigned term;
		sum  = 64'd1 << 24;
		term = 64'd1 << 24;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 24) / k;
			sum += term;
		end
		return sum;
	endfunction

	function automatic void build_exp_lut();
		longint unsigned e;
		longint unsigned einv;
		longint unsigned p;
		longint unsigned v;
		int              whole;
		e    = taylor_exp(64'd1 << 24);
		einv = ((64'd1 << 48) + e / 2) / e;
		for (int k = 0; k <= TBL_DEPTH; k++) begin
			p     = (longint'(k) << 28) / TBL_DEPTH;
			whole = int'(p >> 24) - 8;
			v     = taylor_exp(p & ((64'd1 << 24) - 1));
			while (whole > 0) begin
				v = (v * e) >> 24;
				whole--;
			end
			while (whole < 0) begin
				v = (v * einv) >> 24;
				whole++;
			end
			exp_lut[k] = (v + 128) >> 8;
		end
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// interpolated exp of a clamped Q16 argument
	function automatic longint unsigned exp_interp(longint arg);
		longint unsigned u;
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned fr;
		longint unsigned lo;
		longint unsigned hi;
		if (arg > ARG_CLAMP)
			arg = ARG_CLAMP;
		if (arg < -ARG_CLAMP)
			arg = -ARG_CLAMP;
		u   = longint'(arg + ARG_CLAMP);
		pos = u * TBL_DEPTH;
		idx = pos >> SPAN_BITS;
		fr  = pos & ((64'd1 << SPAN_BITS) - 1);
		if (idx >= TBL_DEPTH)
			return exp_lut[TBL_DEPTH];
		lo = exp_lut[idx];
		hi = exp_lut[idx+1];
		if (hi < lo)
			hi = lo;
		return lo + (((hi - lo) * fr) >> SPAN_BITS);
	endfunction

	// one Euler step of the neuron under the current register copies
	function automatic update_t euler_update(neuron_t n);
		update_t r;
		longint  vm;
		longint  vt;
		longint  x;
		longint  cur;
		longint  ex;
		longint  nvm;
		longint  nvt;
		longint  nx;
		vm  = n.vm;
		vt  = n.vt;
		x   = n.x;
		cur = n.cur;
		ex  = longint'(exp_interp(((vm - vt) * longint'(inv_slope)) >>> 24));
		nvm = clip32(vm + (((rest_pot - vm) * longint'(leak_coeff)) >>> 16)
			+ longint'((exp_gain * longint'(ex)) >> 16)
			+ (((cur - x) * longint'(cur_coeff)) >>> 16));
		nvt = clip32(vt - (((vt - thr_rest) * 64'sd1311) >>> 16));
		nx  = clip32(x + (((vm - rest_pot) * 64'sd1820) >>> 24)
			- ((x * 64'sd455) >>> 16));
		r.spike = 1'b0;
		if (nvm > nvt) begin
			nvm     = reset_pot;
			nvt     = thr_max;
			nx      = clip32(nx + SPIKE_JUMP);
			r.spike = 1'b1;
		end
		r.vm   = nvm[31:0];
		r.vt   = nvt[31:0];
		r.x    = nx[31:0];
		r.tick = n.last;
		return r;
	endfunction

	task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_REST_POTENTIAL:  rest_pot   = longint'(signed'(val));
			REG_INV_SLOPE:       inv_slope  = val[19:0];
			REG_EXP_GAIN:        exp_gain   = val[30:0];
			REG_LEAK_COEFF:      leak_coeff = val[15:0];
			REG_CURRENT_COEFF:   cur_coeff  = val[23:0];
			REG_THRESHOLD_REST:  thr_rest   = longint'(signed'(val));
			REG_RESET_POTENTIAL: reset_pot  = longint'(signed'(val));
			REG_THRESHOLD_MAX:   thr_max    = longint'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
		logic [31:0] v3, logic [31:0] v4, logic [31:0] v5, logic [31:0] v6,
		logic [31:0] v7);
		write_reg(REG_REST_POTENTIAL, v0);
		write_reg(REG_INV_SLOPE, v1);
		write_reg(REG_EXP_GAIN, v2);
		write_reg(REG_LEAK_COEFF, v3);
		write_reg(REG_CURRENT_COEFF, v4);
		write_reg(REG_THRESHOLD_REST, v5);
		write_reg(REG_RESET_POTENTIAL, v6);
		write_reg(REG_THRESHOLD_MAX, v7);
	endtask

	// wait until every update has come back, then let the pipe settle;
	// called just after a falling edge
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_updates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// offer one request; called just after a falling edge
	task automatic send_neuron(neuron_t n);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {n.cur, n.x, n.vt, n.vm};
		s_tlast  = n.last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_volt();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'(int'($urandom_range(200)) - 100) <<< 24;
			2: return {{8{1'b1}}, 24'($urandom())} + 32'($urandom_range(255) << 24);
			default: return 32'(int'($urandom_range(65535)) - 32768);
		endcase
	endfunction

	function automatic neuron_t rand_neuron();
		neuron_t n;
		n.vm = rand_volt();
		// neighbors of the threshold exercise the interpolated exponential
		if ($urandom_range(1))
			n.vt = n.vm + 32'(int'($urandom_range(1 << 27)) - (1 << 26));
		else
			n.vt = rand_volt();
		n.x    = $urandom_range(1) ? $urandom() : 32'(int'($urandom_range(1 << 22)) - (1 << 21));
		n.cur  = $urandom_range(1) ? $urandom() : 32'(int'($urandom_range(1 << 24)) - (1 << 23));
		n.last = $urandom_range(7) == 0;
		return n;
	endfunction

	// receiver: random stall or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready = 1'b0;
			end else
				m_tready = $urandom_range(99) >= recv_stall_pct;
		end
	end

	// accept-side prediction, result check and watchdog
	always @(posedge clk) begin
		update_t exp_u;
		row_t    t;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				exp_u = euler_update('{vm: s_tdata[31:0], vt: s_tdata[63:32],
					x: s_tdata[95:64], cur: s_tdata[127:96], last: s_tlast});
				if (pending_typed.size() != 0) begin
					t = pending_typed.pop_front();
					if (t.typed) begin
						exp_u.vm    = t.vm;
						exp_u.vt    = t.vt;
						exp_u.spike = t.spike;
					end
				end
				pending_updates.push_back(exp_u);
			end
			if (m_tvalid && m_tready) begin
				if (pending_updates.size() == 0) begin
					$display("%0t: unexpected result vm=%h", $time, m_tdata[31:0]);
					error_count++;
				end else begin
					exp_u = pending_updates.pop_front();
					if (m_tdata[31:0] !== exp_u.vm) begin
						$display("%0t: membrane exp %h got %h", $time, exp_u.vm, m_tdata[31:0]);
						error_count++;
					end
					if (m_tdata[63:32] !== exp_u.vt) begin
						$display("%0t: threshold exp %h got %h", $time, exp_u.vt,
							m_tdata[63:32]);
						error_count++;
					end
					if (m_tdata[95:64] !== exp_u.x) begin
						$display("%0t: adaptation exp %h got %h", $time, exp_u.x,
							m_tdata[95:64]);
						error_count++;
					end
					if (m_tuser !== exp_u.spike) begin
						$display("%0t: spike exp %b got %b", $time, exp_u.spike, m_tuser);
						error_count++;
					end
					if (m_tlast !== exp_u.tick) begin
						$display("%0t: tick exp %b got %b", $time, exp_u.tick, m_tlast);
						error_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		row_t    rows [$];
		row_t    r;
		neuron_t n;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_REST_POTENTIAL;
		cfg_wdata   = '0;
		hold_req    = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rest_pot   = -64'sd1184471450;
		inv_slope  = 32768;
		exp_gain   = 3581936;
		leak_coeff = 6997;
		cur_coeff  = 59705;
		thr_rest   = -64'sd754974720;
		reset_pot  = -64'sd1184471450;
		thr_max    = 64'sd301989888;
		build_exp_lut();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners under reset register values
		r.typed = 1'b1;
		// huge positive argument: exponent clamps, voltage saturates, spike
		r.n = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0};
		r.vm = -32'sd1184471450; r.vt = 32'sd301989888; r.spike = 1'b1;
		rows.push_back(r);
		// leak pulls the voltage below the relaxed threshold: no spike
		r.typed = 1'b0;
		r.n = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1};
		rows.push_back(r);
		r.typed = 1'b1;
		r.n = '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1};
		rows.push_back(r);
		r.typed = 1'b0;
		r.n = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0};
		rows.push_back(r);
		r.n = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1};
		rows.push_back(r);
		r.n = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0};
		rows.push_back(r);
		r.n = '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0};
		rows.push_back(r);
		r.n = '{32'hB966_6666, 32'hD300_0000, 32'h0, 32'h0, 1'b1};
		rows.push_back(r);
		r.n = '{32'hB966_6666, 32'hD300_0000, 32'hFFFF_FFFF, 32'h0064_0000, 1'b0};
		rows.push_back(r);
		r.n = '{32'hD200_0000, 32'hD300_0000, 32'h0001_0000, 32'h7FFF_0000, 1'b1};
		rows.push_back(r);
		r.n = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0};
		rows.push_back(r);
		r.n = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1};
		rows.push_back(r);
		foreach (rows[i]) begin
			pending_typed.push_back(rows[i]);
			send_neuron(rows[i].n);
		end
		drain();

		// register settings per phase, extremes among them
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_all(32'hB966_6666, 32'd32768, 32'd3581936, 32'd6997,
					32'd59705, 32'hD300_0000, 32'hB966_6666, 32'h1200_0000);
				1: write_all(32'h7FFF_FFFF, 32'hF_FFFF, 32'h7FFF_FFFF, 32'hFFFF,
					32'hFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
				2: write_all(32'h8000_0000, 32'h0, 32'h0, 32'h0,
					32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
				3: write_all(32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF,
					32'h0, 32'h0, 32'h0, 32'h0);
				default: write_all($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom());
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// idle pattern rotates every 50 requests
				case (((k / 50) + phase) % 5)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
					3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
					default: begin send_idle_pct = 0; recv_stall_pct = 0; end
				endcase
				if (k == 100)
					hold_req = 1'b1;
				if (k == 200)
					drain();
				n = rand_neuron();
				pending_typed.push_back('{n: n, typed: 1'b0, vm: 0, vt: 0, spike: 1'b0});
				send_neuron(n);
			end
			drain();
		end

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
src/adex_pkg.sv
src/adex_exp.sv
src/adex_neuron_euler_step.sv
test/tb_top.sv
